/* rtl/ipv4_udp_checksum_engine_top_macros.svh */
// Assertion macros for the checker file iucse_chk.sv.
// Each macro samples on clk_i and is held off while rst_ni is low.
`ifndef IPV4_UDP_CHECKSUM_ENGINE_TOP_MACROS_SVH
`define IPV4_UDP_CHECKSUM_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define IUCSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iucse checker: same-cycle rule violated");

// Next-cycle implication.
`define IUCSE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iucse checker: next-cycle rule violated");

`endif

/* rtl/iucse_pkg.sv */
package iucse_pkg;

  // Ones'-complement arithmetic
  localparam logic [15:0] WORD_MAX     = 16'hFFFF;
  localparam logic [15:0] UDP_PROTOCOL = 16'd17;
  localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

  // IP header byte positions
  localparam logic [15:0] IP_CKSUM_HI   = 16'd10;
  localparam logic [15:0] IP_CKSUM_LO   = 16'd11;
  localparam logic [15:0] PSEUDO_FIRST  = 16'd12;
  localparam logic [15:0] PSEUDO_END    = 16'd20;
  localparam logic [3:0]  IHL_MIN       = 4'd5;

  // UDP header byte offsets
  localparam logic [15:0] UDP_LEN_HI   = 16'd4;
  localparam logic [15:0] UDP_LEN_LO   = 16'd5;
  localparam logic [15:0] UDP_CKSUM_HI = 16'd6;
  localparam logic [15:0] UDP_CKSUM_LO = 16'd7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_IHL   = 2'd2,
    ST_LONG  = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] ip_checksum;
    logic [15:0] udp_checksum;
    status_e     status;
  } result_t;

  // Fold a sum of up to eight 16-bit terms back into 16 bits (end-around carry twice)
  function automatic logic [15:0] fold(input logic [18:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
    return f2[15:0];
  endfunction

  // Place a byte in the high half on even positions, low half on odd
  function automatic logic [15:0] place(input logic odd, input logic [7:0] b);
    return odd ? {8'h00, b} : {b, 8'h00};
  endfunction

endpackage

/* rtl/iucse_acc.sv */
module iucse_acc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output iucse_pkg::result_t   res_o
);

  logic [15:0] pos_q, pos_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] hsum_q, hsum_d;
  logic [15:0] tsum_q, tsum_d;
  logic [15:0] tlen_q, tlen_d;
  logic [7:0]  held_q, held_d;
  logic        long_q, long_d;

  logic        sat;
  logic [15:0] hb;
  logic        at_udp;
  logic [15:0] off;
  logic [15:0] tlen_now;
  logic [15:0] ext;
  logic [15:0] ext_d;
  logic [15:0] word;
  logic        hdr_en, ps_en, len_en, udp_en;
  logic [16:0] hb_fin;
  logic [16:0] need;

  // Per-word update of position, header fields and both sums
  always_comb begin
    sat      = (pos_q == iucse_pkg::WORD_MAX);
    ihl_d    = (!sat && pos_q == 16'd0) ? byte_i[3:0] : ihl_q;
    hb       = {10'b0, ihl_d, 2'b00};
    at_udp   = (pos_q >= hb);
    off      = pos_q - hb;
    tlen_now = (at_udp && off == iucse_pkg::UDP_LEN_LO) ? {held_q, byte_i} : tlen_q;
    ext      = (tlen_now < iucse_pkg::UDP_HDR_LEN) ? iucse_pkg::UDP_HDR_LEN : tlen_now;
    word     = iucse_pkg::place(pos_q[0], byte_i);

    hdr_en = !sat && (pos_q < hb) && (pos_q != iucse_pkg::IP_CKSUM_HI)
             && (pos_q != iucse_pkg::IP_CKSUM_LO);
    ps_en  = !sat && (pos_q >= iucse_pkg::PSEUDO_FIRST) && (pos_q < iucse_pkg::PSEUDO_END);
    len_en = !sat && at_udp && (off == iucse_pkg::UDP_LEN_LO);
    udp_en = !sat && at_udp && ((off < 16'd6) || ((off < ext)
             && (off != iucse_pkg::UDP_CKSUM_HI) && (off != iucse_pkg::UDP_CKSUM_LO)));

    hsum_d = iucse_pkg::fold({3'b0, hsum_q} + {3'b0, (hdr_en ? word : 16'h0)});
    tsum_d = iucse_pkg::fold({3'b0, tsum_q}
                             + {3'b0, (ps_en  ? word : 16'h0)}
                             + {3'b0, (udp_en ? word : 16'h0)}
                             + {3'b0, (len_en ? iucse_pkg::UDP_PROTOCOL : 16'h0)}
                             + {3'b0, (len_en ? tlen_now : 16'h0)});

    pos_d  = sat ? pos_q : pos_q + 16'd1;
    held_d = (!sat && at_udp && off == iucse_pkg::UDP_LEN_HI) ? byte_i : held_q;
    tlen_d = sat ? tlen_q : tlen_now;
    long_d = long_q | sat;
  end

  // Status and checksums as they stand after this word
  always_comb begin
    ext_d  = (tlen_d < iucse_pkg::UDP_HDR_LEN) ? iucse_pkg::UDP_HDR_LEN : tlen_d;
    hb_fin = {11'b0, ihl_d, 2'b00};
    if ({1'b0, pos_d} >= hb_fin + 17'd6) begin
      need = hb_fin + {1'b0, ext_d};
    end else begin
      need = hb_fin + {1'b0, iucse_pkg::UDP_HDR_LEN};
    end

    res_o.ip_checksum  = ~hsum_d;
    res_o.udp_checksum = ~tsum_d;
    if (ihl_d < iucse_pkg::IHL_MIN) begin
      res_o.status       = iucse_pkg::ST_IHL;
      res_o.ip_checksum  = 16'h0;
      res_o.udp_checksum = 16'h0;
    end else if (long_d) begin
      res_o.status = iucse_pkg::ST_LONG;
    end else if ({1'b0, pos_d} < need) begin
      res_o.status = iucse_pkg::ST_SHORT;
    end else begin
      res_o.status = iucse_pkg::ST_OK;
    end
  end

  // Advance on each word; clear for the next datagram after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ihl_q  <= '0;
      hsum_q <= '0;
      tsum_q <= '0;
      tlen_q <= '0;
      held_q <= '0;
      long_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q  <= '0;
        ihl_q  <= '0;
        hsum_q <= '0;
        tsum_q <= '0;
        tlen_q <= '0;
        held_q <= '0;
        long_q <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        ihl_q  <= ihl_d;
        hsum_q <= hsum_d;
        tsum_q <= tsum_d;
        tlen_q <= tlen_d;
        held_q <= held_d;
        long_q <= long_d;
      end
    end
  end

endmodule

/* rtl/ipv4_udp_checksum_engine_top.sv */
// IPv4 header and UDP checksum engine.
// Slave channel: one datagram byte per word on s_axis_tdata, starting at the first
// IP header byte; s_axis_tlast marks the final byte of the datagram.
// Master channel: one word per datagram, carrying the inverted folded IPv4 header
// checksum and the UDP checksum over pseudo-header and UDP extent, with a status
// code on m_axis_tuser (ok, short packet, IHL below 5, too long).
// Throughput: one byte per cycle, with no gaps between datagrams, unless a last
// byte waits on a full result register that is not being taken. A last byte
// passes the input register, then the result register, which holds the result word.
// The per-byte sum update sits between the input register and the result
// register; a last byte can leave the input register only when the result
// register is empty or being taken.
// Reset clears all sums, counters and both valid flags; the block is ready to take
// a byte in the first cycle after reset.
// Stall: while a result waits, non-last bytes keep flowing; s_axis_tready drops
// only when a further last byte waits and the result register is still occupied.
module ipv4_udp_checksum_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] ip_checksum, [31:16] udp_checksum
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               out_valid_q;
  iucse_pkg::result_t out_q;
  iucse_pkg::result_t res;
  logic               advance;

  // Move the held word on unless it is a last byte facing a full result register
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  iucse_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  // Input valid and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold input and result payloads
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.udp_checksum, out_q.ip_checksum};
  assign m_axis_tuser  = out_q.status;

endmodule

/* rtl/iucse_chk.sv */
`include "ipv4_udp_checksum_engine_top_macros.svh"

module iucse_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic        out_stall;
  logic        ihl_bad;
  logic [33:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign ihl_bad   = m_axis_tvalid && (m_axis_tuser == iucse_pkg::ST_IHL);
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // A stalled result word stays put
  `IUCSE_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

  // Backpressure reaches the input only through a stalled result
  `IUCSE_ASSERT_IMP(a_in_stall_cause, !s_axis_tready, out_stall)

  // A bad header length yields zero checksums
  `IUCSE_ASSERT_IMP(a_ihl_zero, ihl_bad, m_axis_tdata == 32'h0)

endmodule

bind ipv4_udp_checksum_engine_top iucse_chk u_iucse_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
